// ===== rtl/core/bspl_pkg.sv =====
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types, codes and helpers for the BSP point-to-sector lookup.
// ----------------------------------------------------------------------------
package bspl_pkg;

  // Operation codes of an input word
  localparam logic [2:0] OP_QUERY = 3'd0;
  localparam logic [2:0] OP_NODE  = 3'd1;
  localparam logic [2:0] OP_SSEC  = 3'd2;
  localparam logic [2:0] OP_SEG   = 3'd3;
  localparam logic [2:0] OP_LINE  = 3'd4;
  localparam logic [2:0] OP_SIDE  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_NODE_CNT = 3'd0;
  localparam logic [2:0] CFG_SSEC_CNT = 3'd1;
  localparam logic [2:0] CFG_SEG_CNT  = 3'd2;
  localparam logic [2:0] CFG_LINE_CNT = 3'd3;
  localparam logic [2:0] CFG_SIDE_CNT = 3'd4;
  localparam logic [2:0] CFG_SEC_CNT  = 3'd5;

  // Result status codes
  localparam logic [3:0] STAT_OK    = 4'd0;
  localparam logic [3:0] STAT_NODE  = 4'd1;
  localparam logic [3:0] STAT_SSEC  = 4'd2;
  localparam logic [3:0] STAT_SEG   = 4'd3;
  localparam logic [3:0] STAT_LINE  = 4'd4;
  localparam logic [3:0] STAT_SIDEV = 4'd5;
  localparam logic [3:0] STAT_FRONT = 4'd6;
  localparam logic [3:0] STAT_BACK  = 4'd7;
  localparam logic [3:0] STAT_SEC   = 4'd8;
  localparam logic [3:0] STAT_WALK  = 4'd9;

  // Default sizes
  localparam int NODE_ENTRIES_D      = 4096;
  localparam int SUBSECTOR_ENTRIES_D = 4096;
  localparam int SEGMENT_ENTRIES_D   = 8192;
  localparam int LINEDEF_ENTRIES_D   = 4096;
  localparam int SIDEDEF_ENTRIES_D   = 8192;
  localparam int MAX_WALK_D          = 64;

  localparam logic [15:0] LEAF_MASK = 16'h7fff;

  // Kind of work handed from front to back
  typedef enum logic [2:0] {
    K_QUERY,
    K_NODE,
    K_SSEC,
    K_SEG,
    K_LINE,
    K_SIDE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        idx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [15:0]        la;
    logic [15:0]        lb;
  } work_t;

  typedef struct packed {
    logic [12:0] node_cnt;
    logic [12:0] ssec_cnt;
    logic [13:0] seg_cnt;
    logic [12:0] line_cnt;
    logic [13:0] side_cnt;
    logic [15:0] sec_cnt;
  } cfg_t;

  // Back state machine
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_NWAIT,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_SS,
    ST_SEG,
    ST_LINE,
    ST_SIDE,
    ST_SEC,
    ST_DONE
  } st_t;

  // Index is valid when below both its count and the table depth
  function automatic logic in_rng(input logic [15:0] idx, input logic [15:0] cnt,
                                  input int depth);
    logic [16:0] d;
    d = 17'(depth);
    return ({1'b0, idx} < {1'b0, cnt}) && ({1'b0, idx} < d);
  endfunction

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== rtl/core/bspl_ram.sv =====
// ----------------------------------------------------------------------------
// bspl_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bspl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bspl_front.sv =====
// ----------------------------------------------------------------------------
// bspl_front
// Accepts input words, sorts them by kind and drops what has no effect.
// ----------------------------------------------------------------------------
module bspl_front #(
  parameter int NODE_ENTRIES      = bspl_pkg::NODE_ENTRIES_D,
  parameter int SUBSECTOR_ENTRIES = bspl_pkg::SUBSECTOR_ENTRIES_D,
  parameter int SEGMENT_ENTRIES   = bspl_pkg::SEGMENT_ENTRIES_D,
  parameter int LINEDEF_ENTRIES   = bspl_pkg::LINEDEF_ENTRIES_D,
  parameter int SIDEDEF_ENTRIES   = bspl_pkg::SIDEDEF_ENTRIES_D
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_table_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic [15:0]        in_link_a,
  input  logic [15:0]        in_link_b,
  output logic               push,
  output bspl_pkg::work_t    push_word,
  input  logic               q_full
);
  import bspl_pkg::*;

  logic keep;

  assign in_stall = q_full;

  // Classify; unused codes and writes past a table's depth go nowhere
  always_comb begin
    push_word.kind = K_QUERY;
    keep           = 1'b0;
    case (in_operation)
      OP_QUERY: begin
        push_word.kind = K_QUERY;
        keep           = 1'b1;
      end
      OP_NODE: begin
        push_word.kind = K_NODE;
        keep           = in_rng(in_table_index, 16'hffff, NODE_ENTRIES);
      end
      OP_SSEC: begin
        push_word.kind = K_SSEC;
        keep           = in_rng(in_table_index, 16'hffff, SUBSECTOR_ENTRIES);
      end
      OP_SEG: begin
        push_word.kind = K_SEG;
        keep           = in_rng(in_table_index, 16'hffff, SEGMENT_ENTRIES);
      end
      OP_LINE: begin
        push_word.kind = K_LINE;
        keep           = in_rng(in_table_index, 16'hffff, LINEDEF_ENTRIES);
      end
      OP_SIDE: begin
        push_word.kind = K_SIDE;
        keep           = in_rng(in_table_index, 16'hffff, SIDEDEF_ENTRIES);
      end
      default: keep = 1'b0;
    endcase
    // index 0xffff passes only for segment, linedef and sidedef writes whose depth exceeds 65535
    if (in_operation != OP_QUERY && in_table_index == 16'hffff) begin
      keep = keep || ((in_operation == OP_SEG  && SEGMENT_ENTRIES > 65535) ||
                      (in_operation == OP_LINE && LINEDEF_ENTRIES > 65535) ||
                      (in_operation == OP_SIDE && SIDEDEF_ENTRIES > 65535));
    end
    push_word.idx = in_table_index;
    push_word.cx  = in_coord_x;
    push_word.cy  = in_coord_y;
    push_word.dx  = in_dir_x;
    push_word.dy  = in_dir_y;
    push_word.la  = in_link_a;
    push_word.lb  = in_link_b;
  end

  assign push = in_valid && !q_full && keep;

endmodule

// ===== rtl/core/bspl_fifo.sv =====
// ----------------------------------------------------------------------------
// bspl_fifo
// Two-entry queue of work words between the front and the back.
// ----------------------------------------------------------------------------
module bspl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bspl_pkg::work_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output bspl_pkg::work_t head
);
  import bspl_pkg::*;

  work_t       slot_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_word;
    end
  end

endmodule

// ===== rtl/core/bspl_back.sv =====
// ----------------------------------------------------------------------------
// bspl_back
// Holds the tables, applies writes and walks queries to a sector.
// ----------------------------------------------------------------------------
module bspl_back #(
  parameter int NODE_ENTRIES      = bspl_pkg::NODE_ENTRIES_D,
  parameter int SUBSECTOR_ENTRIES = bspl_pkg::SUBSECTOR_ENTRIES_D,
  parameter int SEGMENT_ENTRIES   = bspl_pkg::SEGMENT_ENTRIES_D,
  parameter int LINEDEF_ENTRIES   = bspl_pkg::LINEDEF_ENTRIES_D,
  parameter int SIDEDEF_ENTRIES   = bspl_pkg::SIDEDEF_ENTRIES_D,
  parameter int MAX_WALK          = bspl_pkg::MAX_WALK_D
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bspl_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  bspl_pkg::work_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      out_status,
  output logic [15:0]     out_sector_index,
  output logic [14:0]     out_subsector_index
);
  import bspl_pkg::*;

  localparam int NAW = addr_w(NODE_ENTRIES);
  localparam int SAW = addr_w(SUBSECTOR_ENTRIES);
  localparam int GAW = addr_w(SEGMENT_ENTRIES);
  localparam int LAW = addr_w(LINEDEF_ENTRIES);
  localparam int DAW = addr_w(SIDEDEF_ENTRIES);
  localparam int SW  = $clog2(MAX_WALK + 1);

  st_t                st_r, st_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [SW-1:0]      steps_r, steps_nxt;
  logic signed [31:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [32:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic signed [64:0] p_r, q_r, p_nxt, q_nxt;
  logic [14:0]        ss_r, ss_nxt;
  logic               side_r, side_nxt;
  logic [3:0]         rs_r, rs_nxt;
  logic [15:0]        sec_r, sec_nxt;
  logic               ov_r, ov_nxt;
  logic [3:0]         os_r, os_nxt;
  logic [15:0]        osec_r, osec_nxt;
  logic [14:0]        oss_r, oss_nxt;

  // memory ports
  logic               n_we, s_we, g_we, l_we, d_we;
  logic               n_re, s_re, g_re, l_re, d_re;
  logic [NAW-1:0]     n_ra;
  logic [SAW-1:0]     s_ra;
  logic [GAW-1:0]     g_ra;
  logic [LAW-1:0]     l_ra;
  logic [DAW-1:0]     d_ra;
  logic [159:0]       n_rd;
  logic [15:0]        s_rd, d_rd;
  logic [31:0]        g_rd, l_rd;

  logic signed [31:0] nx, ny, ndx, ndy;
  logic signed [64:0] ox_e, oy_e, dx_e, dy_e;
  logic [15:0]        line_v, sd_v;

  // node row: back, front, dy, dx, ny, nx
  assign nx  = n_rd[31:0];
  assign ny  = n_rd[63:32];
  assign ndx = n_rd[95:64];
  assign ndy = n_rd[127:96];
  assign ox_e = 65'(ox_r);
  assign oy_e = 65'(oy_r);
  assign dx_e = 65'(ndx);
  assign dy_e = 65'(ndy);
  assign line_v = g_rd[15:0];
  assign sd_v   = side_r ? l_rd[31:16] : l_rd[15:0];

  bspl_ram #(.WIDTH(160), .DEPTH(NODE_ENTRIES), .AW(NAW)) u_node (
    .clk(clk), .we(n_we), .waddr(head.idx[NAW-1:0]),
    .wdata({head.lb, head.la, head.dy, head.dx, head.cy, head.cx}),
    .re(n_re), .raddr(n_ra), .rdata(n_rd));
  bspl_ram #(.WIDTH(16), .DEPTH(SUBSECTOR_ENTRIES), .AW(SAW)) u_ssec (
    .clk(clk), .we(s_we), .waddr(head.idx[SAW-1:0]), .wdata(head.la),
    .re(s_re), .raddr(s_ra), .rdata(s_rd));
  bspl_ram #(.WIDTH(32), .DEPTH(SEGMENT_ENTRIES), .AW(GAW)) u_seg (
    .clk(clk), .we(g_we), .waddr(head.idx[GAW-1:0]), .wdata({head.lb, head.la}),
    .re(g_re), .raddr(g_ra), .rdata(g_rd));
  bspl_ram #(.WIDTH(32), .DEPTH(LINEDEF_ENTRIES), .AW(LAW)) u_line (
    .clk(clk), .we(l_we), .waddr(head.idx[LAW-1:0]), .wdata({head.lb, head.la}),
    .re(l_re), .raddr(l_ra), .rdata(l_rd));
  bspl_ram #(.WIDTH(16), .DEPTH(SIDEDEF_ENTRIES), .AW(DAW)) u_side (
    .clk(clk), .we(d_we), .waddr(head.idx[DAW-1:0]), .wdata(head.la),
    .re(d_re), .raddr(d_ra), .rdata(d_rd));

  // next state and datapath
  always_comb begin
    st_nxt    = st_r;
    id_nxt    = id_r;
    steps_nxt = steps_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    ss_nxt    = ss_r;
    side_nxt  = side_r;
    rs_nxt    = rs_r;
    sec_nxt   = sec_r;
    ov_nxt    = ov_r && out_stall;
    os_nxt    = os_r;
    osec_nxt  = osec_r;
    oss_nxt   = oss_r;
    pop  = 1'b0;
    n_we = 1'b0; s_we = 1'b0; g_we = 1'b0; l_we = 1'b0; d_we = 1'b0;
    n_re = 1'b0; s_re = 1'b0; g_re = 1'b0; l_re = 1'b0; d_re = 1'b0;
    n_ra = id_r[NAW-1:0];
    s_ra = ss_r[SAW-1:0];
    g_ra = s_rd[GAW-1:0];
    l_ra = line_v[LAW-1:0];
    d_ra = sd_v[DAW-1:0];
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (head.kind)
            K_NODE: n_we = 1'b1;
            K_SSEC: s_we = 1'b1;
            K_SEG:  g_we = 1'b1;
            K_LINE: l_we = 1'b1;
            K_SIDE: d_we = 1'b1;
            default: begin
              px_nxt    = head.cx;
              py_nxt    = head.cy;
              id_nxt    = {3'b000, cfg.node_cnt} + 16'hffff;
              steps_nxt = '0;
              ss_nxt    = '0;
              st_nxt    = ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (id_r[15]) begin
          ss_nxt = id_r[14:0];
          st_nxt = ST_SS;
        end else if (!in_rng(id_r, {3'b000, cfg.node_cnt}, NODE_ENTRIES)) begin
          rs_nxt = STAT_NODE;
          st_nxt = ST_DONE;
        end else if (steps_r >= SW'(MAX_WALK)) begin
          rs_nxt = STAT_WALK;
          st_nxt = ST_DONE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          n_re      = 1'b1;
          st_nxt    = ST_NWAIT;
        end
      end
      ST_NWAIT: begin
        ox_nxt = 33'(px_r) - 33'(nx);
        oy_nxt = 33'(py_r) - 33'(ny);
        st_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        p_nxt  = ox_e * dy_e;
        st_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        q_nxt  = oy_e * dx_e;
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        // back child when the cross product is at most zero
        id_nxt = (p_r <= q_r) ? n_rd[159:144] : n_rd[143:128];
        st_nxt = ST_WALK;
      end
      ST_SS: begin
        if (!in_rng({1'b0, ss_r}, {3'b000, cfg.ssec_cnt}, SUBSECTOR_ENTRIES)) begin
          rs_nxt = STAT_SSEC;
          st_nxt = ST_DONE;
        end else begin
          s_re   = 1'b1;
          st_nxt = ST_SEG;
        end
      end
      ST_SEG: begin
        if (!in_rng(s_rd, {2'b00, cfg.seg_cnt}, SEGMENT_ENTRIES)) begin
          rs_nxt = STAT_SEG;
          st_nxt = ST_DONE;
        end else begin
          g_re   = 1'b1;
          st_nxt = ST_LINE;
        end
      end
      ST_LINE: begin
        side_nxt = g_rd[16];
        if (!in_rng(line_v, {3'b000, cfg.line_cnt}, LINEDEF_ENTRIES)) begin
          rs_nxt = STAT_LINE;
          st_nxt = ST_DONE;
        end else if (g_rd[31:17] != 15'd0) begin
          rs_nxt = STAT_SIDEV;
          st_nxt = ST_DONE;
        end else begin
          l_re   = 1'b1;
          st_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (!in_rng(sd_v, {2'b00, cfg.side_cnt}, SIDEDEF_ENTRIES)) begin
          rs_nxt = side_r ? STAT_BACK : STAT_FRONT;
          st_nxt = ST_DONE;
        end else begin
          d_re   = 1'b1;
          st_nxt = ST_SEC;
        end
      end
      ST_SEC: begin
        sec_nxt = d_rd;
        rs_nxt  = (d_rd < cfg.sec_cnt) ? STAT_OK : STAT_SEC;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // hand over to the output register once it is free
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          os_nxt   = rs_r;
          osec_nxt = (rs_r == STAT_OK) ? sec_r : 16'd0;
          oss_nxt  = ss_r;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    steps_r <= steps_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    ss_r    <= ss_nxt;
    side_r  <= side_nxt;
    rs_r    <= rs_nxt;
    sec_r   <= sec_nxt;
    os_r    <= os_nxt;
    osec_r  <= osec_nxt;
    oss_r   <= oss_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = os_r;
  assign out_sector_index    = osec_r;
  assign out_subsector_index = oss_r;

endmodule

// ===== rtl/core/bsp_point_sector_lookup.sv =====
// ----------------------------------------------------------------------------
// bsp_point_sector_lookup
// Top level: configuration registers, front classifier, queue and back end.
// ----------------------------------------------------------------------------
// The back end applies a table write as it pops the word. A query leaves
// the queue and walks the tree; each level is a node read, offset, two
// 33x32 multiplies and compare, and a leaf adds the leaf check, the
// subsector, segment, linedef and sidedef reads, the sector check and the
// handover to the output register, which waits while its result stalls. The
// multiply states and the single read port of each table set the length
// of a walk. A two-word queue lets the front accept words until it fills
// while the back end works; the output register holds a result until taken.
module bsp_point_sector_lookup #(
  parameter int NODE_ENTRIES      = bspl_pkg::NODE_ENTRIES_D,
  parameter int SUBSECTOR_ENTRIES = bspl_pkg::SUBSECTOR_ENTRIES_D,
  parameter int SEGMENT_ENTRIES   = bspl_pkg::SEGMENT_ENTRIES_D,
  parameter int LINEDEF_ENTRIES   = bspl_pkg::LINEDEF_ENTRIES_D,
  parameter int SIDEDEF_ENTRIES   = bspl_pkg::SIDEDEF_ENTRIES_D,
  parameter int MAX_WALK          = bspl_pkg::MAX_WALK_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_table_index,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic [15:0]        in_link_a,
  input  logic [15:0]        in_link_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_status,
  output logic [15:0]        out_sector_index,
  output logic [14:0]        out_subsector_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import bspl_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  push, q_full, pop, q_valid;
  work_t push_word, head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_NODE_CNT: cfg_nxt.node_cnt = cfg_data[12:0];
        CFG_SSEC_CNT: cfg_nxt.ssec_cnt = cfg_data[12:0];
        CFG_SEG_CNT:  cfg_nxt.seg_cnt  = cfg_data[13:0];
        CFG_LINE_CNT: cfg_nxt.line_cnt = cfg_data[12:0];
        CFG_SIDE_CNT: cfg_nxt.side_cnt = cfg_data[13:0];
        CFG_SEC_CNT:  cfg_nxt.sec_cnt  = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bspl_front #(
    .NODE_ENTRIES(NODE_ENTRIES), .SUBSECTOR_ENTRIES(SUBSECTOR_ENTRIES),
    .SEGMENT_ENTRIES(SEGMENT_ENTRIES), .LINEDEF_ENTRIES(LINEDEF_ENTRIES),
    .SIDEDEF_ENTRIES(SIDEDEF_ENTRIES)
  ) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_table_index(in_table_index), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_dir_x(in_dir_x), .in_dir_y(in_dir_y),
    .in_link_a(in_link_a), .in_link_b(in_link_b),
    .push(push), .push_word(push_word), .q_full(q_full));

  bspl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word),
    .full(q_full), .pop(pop), .q_valid(q_valid), .head(head));

  bspl_back #(
    .NODE_ENTRIES(NODE_ENTRIES), .SUBSECTOR_ENTRIES(SUBSECTOR_ENTRIES),
    .SEGMENT_ENTRIES(SEGMENT_ENTRIES), .LINEDEF_ENTRIES(LINEDEF_ENTRIES),
    .SIDEDEF_ENTRIES(SIDEDEF_ENTRIES), .MAX_WALK(MAX_WALK)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .head(head),
    .pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_sector_index(out_sector_index),
    .out_subsector_index(out_subsector_index));

endmodule
